// ----- rtl/tick_handler_table_dispatch_assert.svh -----
// ---------------------------------------------------------------------------
// tick handler table assertion macros
// shared concurrent property wrappers, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef TICK_HANDLER_TABLE_DISPATCH_ASSERT_SVH
`define TICK_HANDLER_TABLE_DISPATCH_ASSERT_SVH

// same-cycle implication
`define THTD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tick handler table check failed");

// next-cycle implication
`define THTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tick handler table check failed");

`endif

// ----- rtl/thtd_pkg.sv -----
// ---------------------------------------------------------------------------
// thtd_pkg
// shared codes and the control word broadcast along a cell row
// ---------------------------------------------------------------------------
package thtd_pkg;

  localparam int CNT_W = 4;
  localparam int HND_W = 5;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;
  localparam int SRC_W = 2;
  localparam int ID_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic [CMD_W-1:0] CMD_ATTACH_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ATTACH_SCHED = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DETACH       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK         = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd4;

  localparam logic [SRC_W-1:0] SRC_TICK   = 2'd0;
  localparam logic [SRC_W-1:0] SRC_SCHED  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_STATUS = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE  = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_INVALID   = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ISR_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CT_MODE     = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROT,
    OP_ATTACH
  } list_op_t;

  typedef struct packed {
    list_op_t          op;
    logic              init;     // reload handle pool on attach to empty list
    logic [CNT_W-1:0]  rot_len;  // entries taking part in a rotation
    logic [CNT_W-1:0]  count;    // attach position
    logic [CNT_W-1:0]  limit;    // handle pool size
    logic [HND_W-1:0]  base;     // handle offset of the list
  } list_ctrl_t;

endpackage

// ----- rtl/thtd_cell.sv -----
// ---------------------------------------------------------------------------
// thtd_cell
// one list entry: routine id and handle, loads from neighbor, head or attach
// ---------------------------------------------------------------------------
module thtd_cell #(
  parameter int RW  = 16,
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  thtd_pkg::list_ctrl_t       ctrl,
  input  logic [RW-1:0]              nxt_routine,
  input  logic [thtd_pkg::HND_W-1:0] nxt_handle,
  input  logic [RW-1:0]              wrap_routine,
  input  logic [thtd_pkg::HND_W-1:0] wrap_handle,
  input  logic [RW-1:0]              id,
  output logic [RW-1:0]              routine,
  output logic [thtd_pkg::HND_W-1:0] handle
);

  localparam logic [5:0] IDX6 = 6'(IDX);

  logic                       take_next;
  logic                       take_wrap;
  logic                       in_limit;
  logic                       at_count;
  logic [thtd_pkg::HND_W-1:0] init_hnd;

  assign take_next = (IDX6 + 6'd1) <  {2'b00, ctrl.rot_len};
  assign take_wrap = (IDX6 + 6'd1) == {2'b00, ctrl.rot_len};
  assign in_limit  = IDX6 <  {2'b00, ctrl.limit};
  assign at_count  = IDX6 == {2'b00, ctrl.count};
  assign init_hnd  = 5'({1'b0, ctrl.base} + IDX6 + 6'd1);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      thtd_pkg::OP_ROT: begin
        if (take_next) begin
          routine <= nxt_routine;
          handle  <= nxt_handle;
        end else if (take_wrap) begin
          routine <= wrap_routine;
          handle  <= wrap_handle;
        end
      end
      thtd_pkg::OP_ATTACH: begin
        if (ctrl.init && in_limit) begin
          handle <= init_hnd;
        end
        if (at_count) begin
          routine <= id;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/thtd_list.sv -----
// ---------------------------------------------------------------------------
// thtd_list
// row of entry cells, each handing its contents to the cell below on rotation
// ---------------------------------------------------------------------------
module thtd_list #(
  parameter int DEPTH = 8,
  parameter int RW    = 16
) (
  input  logic                       clk,
  input  thtd_pkg::list_ctrl_t       ctrl,
  input  logic [RW-1:0]              id,
  input  logic [thtd_pkg::CNT_W-1:0] rd_idx,
  output logic [RW-1:0]              head_routine,
  output logic [thtd_pkg::HND_W-1:0] head_handle,
  output logic [RW-1:0]              rd_routine,
  output logic [thtd_pkg::HND_W-1:0] cnt_handle
);

  logic [RW-1:0]              r [DEPTH];
  logic [thtd_pkg::HND_W-1:0] h [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [RW-1:0]              nr;
    logic [thtd_pkg::HND_W-1:0] nh;

    if (i < DEPTH - 1) begin : g_mid
      assign nr = r[i+1];
      assign nh = h[i+1];
    end else begin : g_end
      assign nr = '0;
      assign nh = '0;
    end

    thtd_cell #(
      .RW  (RW),
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .nxt_routine  (nr),
      .nxt_handle   (nh),
      .wrap_routine (r[0]),
      .wrap_handle  (h[0]),
      .id           (id),
      .routine      (r[i]),
      .handle       (h[i])
    );
  end

  assign head_routine = r[0];
  assign head_handle  = h[0];

  // and-or selects over the row
  always_comb begin
    rd_routine = '0;
    cnt_handle = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (6'(i) == {2'b00, rd_idx}) begin
        rd_routine = rd_routine | r[i];
      end
      if (6'(i) == {2'b00, ctrl.count}) begin
        cnt_handle = cnt_handle | h[i];
      end
    end
  end

endmodule

// ----- rtl/tick_handler_table_dispatch.sv -----
// ---------------------------------------------------------------------------
// tick_handler_table_dispatch
// two routine lists with recycled handles, per-tick and round-robin dispatch
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one command per beat (tuser = command, tdata = routine id
//   and handle). m_axis returns result beats (tuser = source, tdata = routine,
//   handle, status); tlast marks the final beat of a command.
//   cfg writes the limits and the cursor mode; keep it quiet while busy.
// result beats:
//   attach, clear and unknown commands: one status beat. tick: one beat per
//   tick-list entry, then at most one scheduled beat; one status beat when
//   nothing goes out. detach: the selected row rotates once over its count
//   entries while the head is compared, then the status beat. a command is
//   taken only in idle, once the previous one has loaded its final beat.
// reset:
//   counts and cursor clear, limits go to their defaults, list cells keep
//   whatever they held (read only after being written). no clearing pass.
// stall:
//   a held result stays in the output register; the next command is taken
//   into the input side meanwhile and waits until the register frees.
// ---------------------------------------------------------------------------
module tick_handler_table_dispatch #(
  parameter int MAX_TICK_SLOTS  = 8,
  parameter int MAX_SCHED_SLOTS = 8,
  parameter int ROUTINE_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // routine_id[15:0], handle[20:16], zero pad
  input  logic [2:0]  s_axis_tuser,   // command[2:0]
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // routine_out[15:0], handle_out[20:16], status[23:21]
  output logic [1:0]  m_axis_tuser,   // source[1:0]
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  `include "tick_handler_table_dispatch_assert.svh"

  localparam int RW = (ROUTINE_BITS < thtd_pkg::ID_W) ? ROUTINE_BITS : thtd_pkg::ID_W;
  // saturation points for the limit registers
  localparam int MT = (MAX_TICK_SLOTS  > 15) ? 15 : MAX_TICK_SLOTS;
  localparam int MS = (MAX_SCHED_SLOTS > 15) ? 15 : MAX_SCHED_SLOTS;
  localparam logic [3:0] MT4 = 4'(MT);
  localparam logic [3:0] MS4 = 4'(MS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_STATUS = 5'b00010,
    S_TICK   = 5'b00100,
    S_SCHED  = 5'b01000,
    S_DETACH = 5'b10000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [3:0] isr_limit;
  logic [3:0] sched_limit;
  logic       ct_mode;

  // list bookkeeping
  logic [3:0] tc, tc_next;
  logic [3:0] sc, sc_next;
  logic [3:0] cursor, cursor_next;

  // per-command working registers
  logic [3:0] steps, steps_next;
  logic [3:0] rot_len, rot_len_next;
  logic       det_tick, det_tick_next;
  logic [4:0] det_h, det_h_next;
  logic       found, found_next;
  logic       sched_hit, sched_hit_next;
  logic [2:0] stat, stat_next;
  logic [4:0] hnd, hnd_next;

  // output register
  logic          out_valid;
  logic [1:0]    out_src, out_src_next;
  logic [RW-1:0] out_routine, out_routine_next;
  logic [4:0]    out_hnd, out_hnd_next;
  logic [2:0]    out_stat, out_stat_next;
  logic          out_last, out_last_next;
  logic          out_load;
  logic          out_free;

  // input fields
  logic [2:0]    in_cmd;
  logic [RW-1:0] in_id;
  logic [4:0]    in_h;
  logic          in_acc;

  // effective limits
  logic [3:0] li;
  logic [3:0] ls;
  logic [4:0] li5;
  logic [4:0] lsum;

  // cursor step for a tick
  logic [4:0] cnt_step;
  logic [3:0] cur_new;
  logic       hit_new;

  // list rows
  thtd_pkg::list_ctrl_t tick_ctrl;
  thtd_pkg::list_ctrl_t sched_ctrl;
  logic [RW-1:0] t_head_routine;
  logic [4:0]    t_head_handle;
  logic [4:0]    t_cnt_handle;
  logic [4:0]    s_head_handle;
  logic [RW-1:0] s_rd_routine;
  logic [4:0]    s_cnt_handle;
  logic [4:0]    det_head;
  logic          det_match;

  assign in_cmd = s_axis_tuser;
  assign in_id  = s_axis_tdata[RW-1:0];
  assign in_h   = s_axis_tdata[20:16];

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign out_free = !out_valid || m_axis_tready;

  assign li   = (isr_limit   > MT4) ? MT4 : isr_limit;
  assign ls   = (sched_limit > MS4) ? MS4 : sched_limit;
  assign li5  = {1'b0, li};
  assign lsum = li5 + {1'b0, ls};

  // round-robin step: constant-time mode walks limit+1 slots
  always_comb begin
    cnt_step = {1'b0, cursor} + 5'd1;
    if (ct_mode) begin
      cur_new = (cursor >= ls) ? 4'd0 : cnt_step[3:0];
      hit_new = cur_new < sc;
    end else if (sc != 4'd0) begin
      cur_new = (cnt_step >= {1'b0, sc}) ? 4'd0 : cnt_step[3:0];
      hit_new = 1'b1;
    end else begin
      cur_new = cursor;
      hit_new = 1'b0;
    end
  end

  assign det_head  = det_tick ? t_head_handle : s_head_handle;
  assign det_match = !found && (det_head == det_h);

  // sequencer
  always_comb begin
    state_next     = state;
    tc_next        = tc;
    sc_next        = sc;
    cursor_next    = cursor;
    steps_next     = steps;
    rot_len_next   = rot_len;
    det_tick_next  = det_tick;
    det_h_next     = det_h;
    found_next     = found;
    sched_hit_next = sched_hit;
    stat_next      = stat;
    hnd_next       = hnd;

    out_load         = 1'b0;
    out_src_next     = thtd_pkg::SRC_STATUS;
    out_routine_next = '0;
    out_hnd_next     = '0;
    out_stat_next    = thtd_pkg::ST_OK;
    out_last_next    = 1'b1;

    tick_ctrl.op       = thtd_pkg::OP_HOLD;
    tick_ctrl.init     = (tc == 4'd0);
    tick_ctrl.rot_len  = rot_len;
    tick_ctrl.count    = tc;
    tick_ctrl.limit    = li;
    tick_ctrl.base     = 5'd0;
    sched_ctrl.op      = thtd_pkg::OP_HOLD;
    sched_ctrl.init    = (sc == 4'd0);
    sched_ctrl.rot_len = rot_len;
    sched_ctrl.count   = sc;
    sched_ctrl.limit   = ls;
    sched_ctrl.base    = li5;

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          hnd_next   = 5'd0;
          state_next = S_STATUS;
          case (in_cmd)
            thtd_pkg::CMD_ATTACH_TICK: begin
              if (tc < li) begin
                tick_ctrl.op = thtd_pkg::OP_ATTACH;
                hnd_next     = (tc == 4'd0) ? 5'd1 : t_cnt_handle;
                tc_next      = tc + 4'd1;
                stat_next    = thtd_pkg::ST_OK;
              end else begin
                stat_next = thtd_pkg::ST_NO_SPACE;
              end
            end
            thtd_pkg::CMD_ATTACH_SCHED: begin
              if (sc < ls) begin
                sched_ctrl.op = thtd_pkg::OP_ATTACH;
                hnd_next      = (sc == 4'd0) ? li5 + 5'd1 : s_cnt_handle;
                sc_next       = sc + 4'd1;
                stat_next     = thtd_pkg::ST_OK;
              end else begin
                stat_next = thtd_pkg::ST_NO_SPACE;
              end
            end
            thtd_pkg::CMD_DETACH: begin
              det_h_next = in_h;
              found_next = 1'b0;
              if (in_h == 5'd0) begin
                stat_next = thtd_pkg::ST_INVALID;
              end else if (in_h <= li5) begin
                det_tick_next = 1'b1;
                if (tc == 4'd0) begin
                  stat_next = thtd_pkg::ST_EMPTY;
                end else begin
                  steps_next   = tc;
                  rot_len_next = tc;
                  state_next   = S_DETACH;
                end
              end else if (in_h <= lsum) begin
                det_tick_next = 1'b0;
                if (sc == 4'd0) begin
                  stat_next = thtd_pkg::ST_EMPTY;
                end else begin
                  steps_next   = sc;
                  rot_len_next = sc;
                  state_next   = S_DETACH;
                end
              end else begin
                stat_next = thtd_pkg::ST_INVALID;
              end
            end
            thtd_pkg::CMD_TICK: begin
              cursor_next    = cur_new;
              sched_hit_next = hit_new;
              stat_next      = thtd_pkg::ST_EMPTY;
              if (tc != 4'd0) begin
                steps_next   = tc;
                rot_len_next = tc;
                state_next   = S_TICK;
              end else if (hit_new) begin
                state_next = S_SCHED;
              end
            end
            thtd_pkg::CMD_CLEAR: begin
              tc_next     = 4'd0;
              sc_next     = 4'd0;
              cursor_next = 4'd0;
              stat_next   = thtd_pkg::ST_OK;
            end
            default: begin
              stat_next = thtd_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_hnd_next  = hnd;
          out_stat_next = stat;
          state_next    = S_IDLE;
        end
      end
      S_TICK: begin
        // emit the head and rotate it to the tail of the occupied part
        if (out_free) begin
          out_load         = 1'b1;
          out_src_next     = thtd_pkg::SRC_TICK;
          out_routine_next = t_head_routine;
          out_last_next    = (steps == 4'd1) && !sched_hit;
          tick_ctrl.op     = thtd_pkg::OP_ROT;
          steps_next       = steps - 4'd1;
          if (steps == 4'd1) begin
            state_next = sched_hit ? S_SCHED : S_IDLE;
          end
        end
      end
      S_SCHED: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_src_next     = thtd_pkg::SRC_SCHED;
          out_routine_next = s_rd_routine;
          state_next       = S_IDLE;
        end
      end
      S_DETACH: begin
        // matched entry lands at the tail, then the rotation shrinks around it
        if (det_tick) begin
          tick_ctrl.op = thtd_pkg::OP_ROT;
        end else begin
          sched_ctrl.op = thtd_pkg::OP_ROT;
        end
        steps_next = steps - 4'd1;
        if (det_match) begin
          found_next   = 1'b1;
          rot_len_next = rot_len - 4'd1;
          if (det_tick) begin
            tc_next = tc - 4'd1;
          end else begin
            sc_next = sc - 4'd1;
          end
        end
        if (steps == 4'd1) begin
          stat_next  = (found || det_match) ? thtd_pkg::ST_OK : thtd_pkg::ST_NOT_FOUND;
          hnd_next   = 5'd0;
          state_next = S_STATUS;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tc          <= 4'd0;
      sc          <= 4'd0;
      cursor      <= 4'd0;
      out_valid   <= 1'b0;
      isr_limit   <= 4'd8;
      sched_limit <= 4'd8;
      ct_mode     <= 1'b0;
    end else begin
      state  <= state_next;
      tc     <= tc_next;
      sc     <= sc_next;
      cursor <= cursor_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          thtd_pkg::CFG_ISR_LIMIT:   isr_limit   <= cfg_data;
          thtd_pkg::CFG_SCHED_LIMIT: sched_limit <= cfg_data;
          thtd_pkg::CFG_CT_MODE:     ct_mode     <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    steps     <= steps_next;
    rot_len   <= rot_len_next;
    det_tick  <= det_tick_next;
    det_h     <= det_h_next;
    found     <= found_next;
    sched_hit <= sched_hit_next;
    stat      <= stat_next;
    hnd       <= hnd_next;
    if (out_load) begin
      out_src     <= out_src_next;
      out_routine <= out_routine_next;
      out_hnd     <= out_hnd_next;
      out_stat    <= out_stat_next;
      out_last    <= out_last_next;
    end
  end

  thtd_list #(
    .DEPTH (MAX_TICK_SLOTS),
    .RW    (RW)
  ) u_tick_list (
    .clk          (clk),
    .ctrl         (tick_ctrl),
    .id           (in_id),
    .rd_idx       (4'd0),
    .head_routine (t_head_routine),
    .head_handle  (t_head_handle),
    .rd_routine   (),
    .cnt_handle   (t_cnt_handle)
  );

  thtd_list #(
    .DEPTH (MAX_SCHED_SLOTS),
    .RW    (RW)
  ) u_sched_list (
    .clk          (clk),
    .ctrl         (sched_ctrl),
    .id           (in_id),
    .rd_idx       (cursor),
    .head_routine (),
    .head_handle  (s_head_handle),
    .rd_routine   (s_rd_routine),
    .cnt_handle   (s_cnt_handle)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_stat, out_hnd, thtd_pkg::ID_W'(out_routine)};
  assign m_axis_tuser  = out_src;
  assign m_axis_tlast  = out_last;

  // checks
  `THTD_ASSERT_NOW(a_tc_range, 1'b1, tc <= MT4 && sc <= MS4)
  `THTD_ASSERT_NOW(a_detach_len, state == S_DETACH, rot_len != 4'd0 && steps != 4'd0)
  `THTD_ASSERT_NEXT(a_tick_end, state == S_TICK && out_free && steps == 4'd1 && !sched_hit,
                    state == S_IDLE && out_last)
  `THTD_ASSERT_NEXT(a_det_dec, state == S_DETACH && det_match && det_tick,
                    tc == $past(tc) - 4'd1)

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: tick handler table dispatch testbench
// drives command beats into s_axis, predicts every result beat with its own
// copy of both routine lists, the handle pools and the round-robin cursor,
// and checks m_axis beat by beat. a short directed table comes first, then
// random traffic over several limit and cursor-mode settings with random
// idling on both sides and one long result hold-off.
// ---------------------------------------------------------------------------
module tb;
  import thtd_pkg::*;

  // unknown command codes, answered with an invalid status
  localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

  localparam int LIST_TICK    = 0;
  localparam int LIST_SCHED   = 1;
  localparam int SLOTS        = 8;
  localparam int SETTLE       = 24;       // longest command (detach, full row) plus margin
  localparam int HOLD_LEN     = 300;      // long result hold-off, in cycles
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PER_SET = 21;
  localparam int MAX_REPORTS  = 60;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [ID_W-1:0]  routine;
    logic [HND_W-1:0] hnd;
    logic [ST_W-1:0]  st;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [HND_W-1:0] hnd;
    logic             typed;  // exp holds the answer, not the predictor
    beat_t            exp;
  } stim_row_t;

  typedef struct packed {
    logic [3:0] isr;
    logic [3:0] sched;
    logic       ct;
    int         send_pct;
    int         recv_pct;
    logic       pressure;
  } setting_t;

  localparam beat_t NO_BEAT = '0;

  // directed table, reset limits (8 tick slots, 8 scheduled slots, counting cursor)
  localparam int N_DIR = 26;
  localparam stim_row_t DIRECTED [N_DIR] = '{
    // nothing attached yet
    '{CMD_TICK,         16'h0000, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_EMPTY,    1'b1}},
    '{CMD_DETACH,       16'h0000, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_INVALID,  1'b1}},
    '{CMD_DETACH,       16'h0000, 5'd3,  1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_EMPTY,    1'b1}},
    '{CMD_DETACH,       16'hffff, 5'd31, 1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_INVALID,  1'b1}},
    '{CMD_DETACH,       16'h0000, 5'd16, 1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_EMPTY,    1'b1}},
    '{CMD_BAD_LO,       16'h0000, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_INVALID,  1'b1}},
    '{CMD_BAD_HI,       16'hffff, 5'd31, 1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_INVALID,  1'b1}},
    // first attaches take the pools in order, scheduled handles start above 8
    '{CMD_ATTACH_TICK,  16'hffff, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd1,  ST_OK,       1'b1}},
    '{CMD_ATTACH_TICK,  16'h0000, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd2,  ST_OK,       1'b1}},
    '{CMD_ATTACH_SCHED, 16'ha5a5, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd9,  ST_OK,       1'b1}},
    '{CMD_ATTACH_SCHED, 16'h5a5a, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd10, ST_OK,       1'b1}},
    '{CMD_TICK,         16'h0000, 5'd0,  1'b0, NO_BEAT},
    // fill the tick list
    '{CMD_ATTACH_TICK,  16'h1111, 5'd0,  1'b0, NO_BEAT},
    '{CMD_ATTACH_TICK,  16'h2222, 5'd0,  1'b0, NO_BEAT},
    '{CMD_ATTACH_TICK,  16'h4444, 5'd0,  1'b0, NO_BEAT},
    '{CMD_ATTACH_TICK,  16'h8888, 5'd0,  1'b0, NO_BEAT},
    '{CMD_ATTACH_TICK,  16'h1234, 5'd0,  1'b0, NO_BEAT},
    '{CMD_ATTACH_TICK,  16'hfedc, 5'd0,  1'b0, NO_BEAT},
    '{CMD_ATTACH_TICK,  16'h0bad, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_NO_SPACE, 1'b1}},
    // middle detach, then the same handle again, then reuse of the parked handle
    '{CMD_DETACH,       16'h0000, 5'd2,  1'b0, NO_BEAT},
    '{CMD_DETACH,       16'h0000, 5'd2,  1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_NOT_FOUND, 1'b1}},
    '{CMD_ATTACH_TICK,  16'h7777, 5'd0,  1'b0, NO_BEAT},
    // full tick list plus one scheduled routine: the longest burst
    '{CMD_TICK,         16'h0000, 5'd0,  1'b0, NO_BEAT},
    '{CMD_DETACH,       16'h0000, 5'd10, 1'b0, NO_BEAT},
    '{CMD_CLEAR,        16'h0000, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_OK,       1'b1}},
    '{CMD_TICK,         16'h0000, 5'd0,  1'b1, '{SRC_STATUS, 16'h0, 5'd0,  ST_EMPTY,    1'b1}}
  };

  // register settings for the random part, idling as the run goes on:
  // sender light / receiver heavy, then the reverse, then no idling at all
  localparam int N_SET = 6;
  localparam setting_t SETTINGS [N_SET] = '{
    '{4'd15, 4'd8,  1'b1, 36, 88, 1'b0},   // tick limit above table size
    '{4'd3,  4'd5,  1'b0, 36, 88, 1'b0},
    '{4'd8,  4'd15, 1'b1, 88, 36, 1'b0},   // raised limits on non-empty lists
    '{4'd0,  4'd0,  1'b0, 88, 36, 1'b0},   // both lists closed
    '{4'd8,  4'd2,  1'b1, 0,  0,  1'b1},   // long hold-off on results
    '{4'd1,  4'd8,  1'b0, 0,  0,  1'b0}
  };

  // -------------------------------------------------------------------------
  // clock, reset, dut
  // -------------------------------------------------------------------------
  logic clk;
  logic rst = 1'b1;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;
  logic [CMD_W-1:0]  s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic [SRC_W-1:0]  m_axis_tuser;
  logic              m_axis_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  tick_handler_table_dispatch i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // routine_id[15:0], handle[20:16], zero pad
    .s_axis_tuser  (s_axis_tuser),   // command[2:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // routine_out[15:0], handle_out[20:16], status[23:21]
    .m_axis_tuser  (m_axis_tuser),   // source[1:0]
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // -------------------------------------------------------------------------
  // predictor state: both lists, their handle pools and the cursor
  // -------------------------------------------------------------------------
  logic [ID_W-1:0]  ids_mem [2][SLOTS];
  logic [HND_W-1:0] hnd_mem [2][SLOTS];
  bit               hnd_set [2][SLOTS];   // handle entry written at least once
  int               cnt [2];
  int               cursor;
  int               isr_lim   = 8;
  int               sched_lim = 8;
  bit               ct_mode   = 1'b0;

  beat_t due_beats [$];   // result beats still owed by the dut, oldest first

  int  errors      = 0;
  int  cycles      = 0;
  int  send_pct    = 0;
  int  recv_pct    = 0;
  bit  hold_req    = 1'b0;
  int  hold_cycles = 0;

  initial begin
    for (int l = 0; l < 2; l++) begin
      cnt[l] = 0;
      for (int i = 0; i < SLOTS; i++) hnd_set[l][i] = 1'b0;
    end
    cursor = 0;
  end

  // limits saturate at the table size
  function automatic int eff_lim(input int l);
    int raw;
    raw = (l == LIST_TICK) ? isr_lim : sched_lim;
    return (raw > SLOTS) ? SLOTS : raw;
  endfunction

  function automatic logic [ST_W-1:0] list_attach(input int l, input int lim, input int base,
                                                  input logic [ID_W-1:0] id,
                                                  output logic [HND_W-1:0] h);
    h = '0;
    // empty list: handle pool set up again in order
    if (cnt[l] == 0) begin
      for (int i = 0; i < lim; i++) begin
        hnd_mem[l][i] = HND_W'(base + i + 1);
        hnd_set[l][i] = 1'b1;
      end
    end
    if (cnt[l] < lim) begin
      ids_mem[l][cnt[l]] = id;
      h = hnd_mem[l][cnt[l]];
      cnt[l]++;
      return ST_OK;
    end
    return ST_NO_SPACE;
  endfunction

  function automatic logic [ST_W-1:0] list_detach(input int l, input logic [HND_W-1:0] h);
    if (cnt[l] == 0) return ST_EMPTY;
    for (int i = 0; i < cnt[l]; i++) begin
      if (hnd_mem[l][i] == h) begin
        for (int j = i; j + 1 < cnt[l]; j++) begin
          hnd_mem[l][j] = hnd_mem[l][j+1];
          ids_mem[l][j] = ids_mem[l][j+1];
        end
        cnt[l]--;
        // freed handle parks at the new end for the next attach
        hnd_mem[l][cnt[l]] = h;
        hnd_set[l][cnt[l]] = 1'b1;
        return ST_OK;
      end
    end
    return ST_NOT_FOUND;
  endfunction

  task automatic owe_beat(input logic [SRC_W-1:0] src, input logic [ID_W-1:0] routine,
                          input logic [HND_W-1:0] h, input logic [ST_W-1:0] st);
    beat_t b;
    b = '{src, routine, h, st, 1'b0};
    due_beats.push_back(b);
  endtask

  // works out the result beats of one accepted command and updates the lists
  task automatic table_step(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                            input logic [HND_W-1:0] h);
    int li, ls, n0, nx;
    logic [HND_W-1:0] hout;
    logic [ST_W-1:0] st;
    li = eff_lim(LIST_TICK);
    ls = eff_lim(LIST_SCHED);
    n0 = due_beats.size();
    case (cmd)
      CMD_ATTACH_TICK: begin
        st = list_attach(LIST_TICK, li, 0, id, hout);
        owe_beat(SRC_STATUS, '0, hout, st);
      end
      CMD_ATTACH_SCHED: begin
        st = list_attach(LIST_SCHED, ls, li, id, hout);
        owe_beat(SRC_STATUS, '0, hout, st);
      end
      CMD_DETACH: begin
        // route by handle range: tick pool first, scheduled pool above it
        if (h == '0) st = ST_INVALID;
        else if (int'(h) <= li) st = list_detach(LIST_TICK, h);
        else if (int'(h) <= li + ls) st = list_detach(LIST_SCHED, h);
        else st = ST_INVALID;
        owe_beat(SRC_STATUS, '0, '0, st);
      end
      CMD_TICK: begin
        for (int i = 0; i < cnt[LIST_TICK] && i < SLOTS; i++)
          owe_beat(SRC_TICK, ids_mem[LIST_TICK][i], '0, ST_OK);
        if (ct_mode) begin
          // constant-time cursor walks limit+1 positions, dispatching only inside the list
          cursor = (cursor >= ls) ? 0 : cursor + 1;
          if (cursor < cnt[LIST_SCHED] && cursor < SLOTS)
            owe_beat(SRC_SCHED, ids_mem[LIST_SCHED][cursor], '0, ST_OK);
        end else if (cnt[LIST_SCHED] != 0) begin
          nx = cursor + 1;
          if (nx >= cnt[LIST_SCHED]) nx = 0;
          cursor = nx & 15;
          if (cursor < SLOTS)
            owe_beat(SRC_SCHED, ids_mem[LIST_SCHED][cursor], '0, ST_OK);
        end
        if (due_beats.size() == n0) owe_beat(SRC_STATUS, '0, '0, ST_EMPTY);
      end
      CMD_CLEAR: begin
        cnt[LIST_TICK]  = 0;
        cnt[LIST_SCHED] = 0;
        cursor = 0;
        owe_beat(SRC_STATUS, '0, '0, ST_OK);
      end
      default: owe_beat(SRC_STATUS, '0, '0, ST_INVALID);
    endcase
    due_beats[due_beats.size()-1].last = 1'b1;
  endtask

  // -------------------------------------------------------------------------
  // command side: random gaps, beat held until accepted
  // -------------------------------------------------------------------------
  // call at a falling edge; returns at the falling edge after acceptance with
  // tvalid still high so that back-to-back beats never drop it
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                          input logic [HND_W-1:0] h, input logic typed, input beat_t exp);
    int n0;
    while ($urandom_range(99) < send_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, h, id};
    do @(posedge clk); while (!s_axis_tready);
    n0 = due_beats.size();
    table_step(cmd, id, h);
    // typed rows: state still follows the predictor, the answer comes from the row
    if (typed) begin
      while (due_beats.size() > n0) void'(due_beats.pop_back());
      due_beats.push_back(exp);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ISR_LIMIT:   isr_lim   = int'(val);
      CFG_SCHED_LIMIT: sched_lim = int'(val);
      CFG_CT_MODE:     ct_mode   = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // stop offering, wait for every owed beat, then let the block go quiet
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // random command, mostly well-formed: attaches, detaches of live handles,
  // ticks; the rest stray handles, clears and unknown codes
  task automatic draw_cmd(output logic [CMD_W-1:0] cmd, output logic [ID_W-1:0] id,
                          output logic [HND_W-1:0] h);
    int r, l, lim;
    r   = $urandom_range(99);
    id  = ID_W'($urandom);
    h   = HND_W'($urandom_range(31));
    if (r < 25) cmd = CMD_ATTACH_TICK;
    else if (r < 45) cmd = CMD_ATTACH_SCHED;
    else if (r < 65) begin
      cmd = CMD_DETACH;
      if (cnt[LIST_TICK] != 0 || cnt[LIST_SCHED] != 0) begin
        l = $urandom_range(1);
        if (cnt[l] == 0) l = 1 - l;
        h = hnd_mem[l][$urandom_range(cnt[l] - 1)];
      end
    end
    else if (r < 75) cmd = CMD_DETACH;
    else if (r < 93) cmd = CMD_TICK;
    else if (r < 96) cmd = CMD_CLEAR;
    else cmd = CMD_CLEAR + CMD_W'($urandom_range(1, 3));

    // an attach must not pick up a handle entry that was never written
    if (cmd == CMD_ATTACH_TICK || cmd == CMD_ATTACH_SCHED) begin
      l   = (cmd == CMD_ATTACH_TICK) ? LIST_TICK : LIST_SCHED;
      lim = eff_lim(l);
      if (cnt[l] > 0 && cnt[l] < lim && !hnd_set[l][cnt[l]]) cmd = CMD_TICK;
    end
  endtask

  // -------------------------------------------------------------------------
  // result side: random stalls plus one long hold-off counted here
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req && hold_cycles < HOLD_LEN) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  task automatic report(input string fld, input logic [15:0] want, input logic [15:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fld, want, got);
  endtask

  // compare each accepted result beat with the oldest owed one
  always @(posedge clk) begin
    beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_beats.size() == 0) begin
        report("unexpected beat, tdata", 16'h0, m_axis_tdata[15:0]);
      end else begin
        want = due_beats.pop_front();
        if (m_axis_tuser !== want.src)
          report("source", 16'(want.src), 16'(m_axis_tuser));
        if (m_axis_tdata[15:0] !== want.routine)
          report("routine_out", want.routine, m_axis_tdata[15:0]);
        if (m_axis_tdata[20:16] !== want.hnd)
          report("handle_out", 16'(want.hnd), 16'(m_axis_tdata[20:16]));
        if (m_axis_tdata[23:21] !== want.st)
          report("status", 16'(want.st), 16'(m_axis_tdata[23:21]));
        if (m_axis_tlast !== want.last)
          report("last", 16'(want.last), 16'(m_axis_tlast));
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [HND_W-1:0] h;

    // reset asserted from the start, released at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset limits, light sender, heavy receiver
    send_pct = 36;
    recv_pct = 88;
    for (int i = 0; i < N_DIR; i++)
      send_cmd(DIRECTED[i].cmd, DIRECTED[i].id, DIRECTED[i].hnd,
               DIRECTED[i].typed, DIRECTED[i].exp);

    // random part, one block of commands per register setting
    for (int s = 0; s < N_SET; s++) begin
      drain();
      write_reg(CFG_ISR_LIMIT,   SETTINGS[s].isr);
      write_reg(CFG_SCHED_LIMIT, SETTINGS[s].sched);
      write_reg(CFG_CT_MODE,     {3'b000, SETTINGS[s].ct});
      cfg_valid <= 1'b0;
      send_pct = SETTINGS[s].send_pct;
      recv_pct = SETTINGS[s].recv_pct;
      // results held back while commands keep coming, so the input backs up
      if (SETTINGS[s].pressure) hold_req <= 1'b1;
      repeat (RAND_PER_SET) begin
        draw_cmd(cmd, id, h);
        send_cmd(cmd, id, h, 1'b0, NO_BEAT);
      end
    end

    drain();
    if (errors == 0 && due_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/thtd_pkg.sv
rtl/thtd_cell.sv
rtl/thtd_list.sv
rtl/tick_handler_table_dispatch.sv
dv/tb.sv
